// ===== rtl/arpt_pkg.sv =====
// Shared types and constants for the ARP table with aging.
// No dependencies; imported by every module of the block.
`default_nettype none

package arpt_pkg;

  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int STAMP_W = 32;
  localparam int AGE_W   = 16;
  localparam int SLOT_W  = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [AGE_W-1:0] AGE_RESET = 16'd15;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  typedef enum logic [0:0] {
    REG_AGE_LIMIT = 1'b0
  } reg_idx_t;

  // Broadcast from the control path to every table entry.
  typedef struct packed {
    logic               tick;
    logic [IP_W-1:0]    ip;
    logic [MAC_W-1:0]   mac;
    logic [STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0] now_next;
    logic [AGE_W-1:0]   age_limit;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/arpt_cfg.sv =====
// APB-style register block holding the age limit.
// Depends on arpt_pkg.
`default_nettype none

module arpt_cfg
  import arpt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic      [AGE_W-1:0]   age_limit
);

  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == REG_AGE_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit <= AGE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      age_limit <= pwdata[AGE_W-1:0];
    end
  end

  assign prdata = reg_sel ? PDATA_W'(age_limit) : '0;

endmodule

`default_nettype wire

// ===== rtl/arpt_cell.sv =====
// One table entry: stored address pair and stamp, address compare, age check.
// Depends on arpt_pkg.
`default_nettype none

module arpt_cell
  import arpt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire cell_cmd_t        cmd,
  output logic                  valid,
  output logic                  match,
  output logic      [MAC_W-1:0] mac
);

  logic [IP_W-1:0]    ip;
  logic [STAMP_W-1:0] stamp;
  logic [STAMP_W-1:0] age;
  logic               expire;

  assign age    = cmd.now_next - stamp;
  assign expire = cmd.tick && (age > STAMP_W'(cmd.age_limit));
  assign match  = valid && (ip == cmd.ip);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr) begin
      valid <= 1'b1;
    end else if (expire) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      ip    <= cmd.ip;
      mac   <= cmd.mac;
      stamp <= cmd.stamp;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/arp_table_with_aging.sv =====
// ARP table with aging: request register, parallel entry compare, result register.
// A taken request passes the request register, then the result register; one request per cycle unless out_stall holds.
// Rate is set by the single pass through the entry compare and priority pick.
// Reset clears all valid bits, the seconds counter and sets age_limit to 15.
// Entry contents are not cleared; there is no clearing pass.
// Depends on arpt_pkg, arpt_cfg, arpt_cell.
`default_nettype none

module arp_table_with_aging
  import arpt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         opcode,
  input  wire logic [IP_W-1:0]    ip_address,
  input  wire logic [MAC_W-1:0]   mac_address,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    hit,
  output logic      [MAC_W-1:0]   found_mac,
  output logic      [SLOT_W-1:0]  slot,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam logic [TABLE_ENTRIES-1:0] LAST_ONEHOT = {1'b1, {(TABLE_ENTRIES-1){1'b0}}};

  logic [AGE_W-1:0]   age_limit;
  logic               s1_valid;
  logic [1:0]         s1_op;
  logic [IP_W-1:0]    s1_ip;
  logic [MAC_W-1:0]   s1_mac;
  logic [STAMP_W-1:0] seconds;
  logic               advance;
  logic               load;
  logic               do_insert;
  logic               do_tick;
  cell_cmd_t          cmd;

  logic [TABLE_ENTRIES-1:0] valid_vec;
  logic [TABLE_ENTRIES-1:0] match_vec;
  logic [TABLE_ENTRIES-1:0] match_first;
  logic [TABLE_ENTRIES-1:0] free_vec;
  logic [TABLE_ENTRIES-1:0] free_first;
  logic [TABLE_ENTRIES-1:0] ins_pos;
  logic [MAC_W-1:0]         cell_mac [TABLE_ENTRIES];

  logic               hit_next;
  logic [MAC_W-1:0]   found_mac_next;
  logic [SLOT_W-1:0]  slot_next;
  logic [SLOT_W-1:0]  match_slot;
  logic [SLOT_W-1:0]  ins_slot;

  arpt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .age_limit (age_limit)
  );

  // handshake
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_op  <= opcode;
      s1_ip  <= ip_address;
      s1_mac <= mac_address;
    end
  end

  assign do_insert = advance && (s1_op == OP_INSERT);
  assign do_tick   = advance && (s1_op == OP_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds <= '0;
    end else if (do_tick) begin
      seconds <= seconds + STAMP_W'(1);
    end
  end

  assign cmd.tick      = do_tick;
  assign cmd.ip        = s1_ip;
  assign cmd.mac       = s1_mac;
  assign cmd.stamp     = seconds;
  assign cmd.now_next  = seconds + STAMP_W'(1);
  assign cmd.age_limit = age_limit;

  // entries
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    arpt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .wr    (do_insert && ins_pos[g]),
      .cmd   (cmd),
      .valid (valid_vec[g]),
      .match (match_vec[g]),
      .mac   (cell_mac[g])
    );
  end

  // lowest-index pick; when no entry is free, an insert overwrites the last entry
  assign match_first = match_vec & (~match_vec + TABLE_ENTRIES'(1));
  assign free_vec    = ~valid_vec;
  assign free_first  = free_vec & (~free_vec + TABLE_ENTRIES'(1));
  assign ins_pos     = (|free_vec) ? free_first : LAST_ONEHOT;

  always_comb begin
    found_mac_next = '0;
    match_slot     = '0;
    ins_slot       = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (match_first[i]) begin
        found_mac_next = found_mac_next | cell_mac[i];
        match_slot     = match_slot | SLOT_W'(i);
      end
      if (ins_pos[i]) begin
        ins_slot = ins_slot | SLOT_W'(i);
      end
    end
  end

  always_comb begin
    hit_next = 1'b0;
    slot_next = '0;
    case (s1_op)
      OP_LOOKUP: begin
        hit_next  = |match_vec;
        slot_next = match_slot;
      end
      OP_INSERT: begin
        slot_next = ins_slot;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit       <= hit_next;
      found_mac <= hit_next ? found_mac_next : '0;
      slot      <= slot_next;
    end
  end

endmodule

`default_nettype wire
